FILE: sv/prb_pkg.sv
// Shared constants, types and helpers of the packet reorder buffer.
`default_nettype none

package prb_pkg;

    localparam int RING_SLOTS  = 32;
    localparam int SLOT_W      = $clog2(RING_SLOTS);
    localparam int GROUP_SIZE  = 8;
    localparam int NUM_GROUPS  = (RING_SLOTS + GROUP_SIZE - 1) / GROUP_SIZE;
    localparam int PAD_SLOTS   = NUM_GROUPS * GROUP_SIZE;
    localparam int BACKLOG_W   = SLOT_W + 1;

    localparam int KIND_W      = 3;
    localparam int BYTE_W      = 8;
    localparam int HANDLE_W    = 16;
    localparam int CODE_W      = 2;
    localparam int SLOT_IDX_W  = 5;
    localparam int LIMIT_W     = 5;
    localparam int SKIP_W      = 6;
    localparam int CFG_IDX_W   = 8;
    localparam int CFG_DATA_W  = 8;

    localparam int SYM_COUNT   = 36;
    localparam int DIGIT_COUNT = 10;
    localparam int EXP_W       = 6;

    localparam logic [BYTE_W-1:0] SYM_FIRST_DIGIT = 8'h30;
    localparam logic [BYTE_W-1:0] SYM_FIRST_UPPER = 8'h41;
    localparam logic [BYTE_W-1:0] FRAME_START     = 8'h73;
    localparam logic [BYTE_W-1:0] FRAME_END       = 8'h65;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd5;
    localparam logic [SKIP_W-1:0]  SKIP_RESET  = 6'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_BACKLOG_LIMIT = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SKIP_COUNT    = 8'd1;

    localparam logic RESULT_NOTICE = 1'b0;
    localparam logic RESULT_PACKET = 1'b1;

    typedef enum logic [KIND_W-1:0] {
        KIND_READY = 3'd0,
        KIND_DONE  = 3'd1,
        KIND_START = 3'd2,
        KIND_STOP  = 3'd3,
        KIND_DATA  = 3'd4,
        KIND_OTHER = 3'd5
    } msg_kind_t;

    typedef struct packed {
        logic wr_en;
        logic clr_en;
    } cell_ctrl_t;

    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] idx;
    } pick_t;

    function automatic logic [BYTE_W-1:0] sym_of(input logic [EXP_W-1:0] idx);
        logic [BYTE_W-1:0] s;
        if (idx < EXP_W'(DIGIT_COUNT))
        begin
            s = SYM_FIRST_DIGIT + BYTE_W'(idx);
        end
        else
        begin
            s = SYM_FIRST_UPPER + BYTE_W'(idx) - BYTE_W'(DIGIT_COUNT);
        end
        return s;
    endfunction

endpackage

`default_nettype wire

FILE: sv/prb_if.sv
// Request channel interfaces: datagram input, result output, register write.
`default_nettype none

interface prb_in_if import prb_pkg::*;;
    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   msg_kind;
    logic [BYTE_W-1:0]   first_byte;
    logic [BYTE_W-1:0]   last_byte;
    logic [BYTE_W-1:0]   seq_code;
    logic [HANDLE_W-1:0] payload_handle;

    modport source (output valid, msg_kind, first_byte, last_byte, seq_code, payload_handle,
                    input ready);
    modport sink   (input valid, msg_kind, first_byte, last_byte, seq_code, payload_handle,
                    output ready);
endinterface

interface prb_out_if import prb_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic                  result_kind;
    logic [CODE_W-1:0]     notice_code;
    logic [HANDLE_W-1:0]   packet_handle;
    logic [SLOT_IDX_W-1:0] slot_index;
    logic [BYTE_W-1:0]     released_seq;
    logic                  is_last;

    modport source (output valid, result_kind, notice_code, packet_handle, slot_index,
                    released_seq, is_last, input ready);
    modport sink   (input valid, result_kind, notice_code, packet_handle, slot_index,
                    released_seq, is_last, output ready);
endinterface

interface prb_cfg_if import prb_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: sv/prb_cell.sv
// One ring slot: stored symbol and handle, valid flag, registered match and hit chain.
`default_nettype none

module prb_cell import prb_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire cell_ctrl_t          ctrl,
    input  wire logic [BYTE_W-1:0]   wr_sym,
    input  wire logic [HANDLE_W-1:0] wr_pay,
    input  wire logic [BYTE_W-1:0]   exp_sym,
    input  wire logic                hit_in,
    output logic                     hit_out,
    output logic                     first,
    output logic [BYTE_W-1:0]        sym,
    output logic [HANDLE_W-1:0]      pay
);

    logic                valid_reg;
    logic                valid_next;
    logic                match_reg;
    logic                match_next;
    logic [BYTE_W-1:0]   sym_reg;
    logic [HANDLE_W-1:0] pay_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (ctrl.wr_en)
        begin
            valid_next = 1'b1;
        end
        else if (ctrl.clr_en)
        begin
            valid_next = 1'b0;
        end
        match_next = valid_reg && (sym_reg == exp_sym);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            match_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            match_reg <= match_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
        begin
            sym_reg <= wr_sym;
            pay_reg <= wr_pay;
        end
    end

    assign hit_out = hit_in | match_reg;
    assign first   = match_reg & ~hit_in;
    assign sym     = sym_reg;
    assign pay     = pay_reg;

endmodule

`default_nettype wire

FILE: sv/prb_pick.sv
// Registered group stage: picks the lowest matching slot across cell groups.
`default_nettype none

module prb_pick import prb_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic [RING_SLOTS-1:0] first,
    output pick_t                      pick
);

    logic [PAD_SLOTS-1:0]  first_reg;
    logic [NUM_GROUPS-1:0] any_group;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg <= '0;
        end
        else
        begin
            first_reg <= PAD_SLOTS'(first);
        end
    end

    always_comb
    begin
        int sel_g;
        int sel_l;
        sel_g = 0;
        sel_l = 0;
        for (int g = 0; g < NUM_GROUPS; g++)
        begin
            any_group[g] = |first_reg[g*GROUP_SIZE +: GROUP_SIZE];
        end
        for (int g = NUM_GROUPS - 1; g >= 0; g--)
        begin
            if (any_group[g])
            begin
                sel_g = g;
            end
        end
        for (int l = 0; l < GROUP_SIZE; l++)
        begin
            if (first_reg[sel_g*GROUP_SIZE + l])
            begin
                sel_l = sel_l | l;
            end
        end
        pick.hit = |any_group;
        pick.idx = SLOT_W'(sel_g * GROUP_SIZE + sel_l);
    end

endmodule

`default_nettype wire

FILE: sv/packet_reorder_buffer_top.sv
// Packet reorder buffer top: ring of slot cells, group picker and release sequencer.
// Control words: result registered in the cycle after the request; one request per cycle
// while the result output is free. Framed datagram: a write, then scan rounds of match,
// group and pick. Each release is held until the next scan shows whether it is the last
// one. Reset: async, all slots invalid, pointers zero, symbol '0'.
`default_nettype none

module packet_reorder_buffer_top import prb_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    prb_in_if.sink    pkt,
    prb_out_if.source result,
    prb_cfg_if.sink   cfg
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WAIT1,
        ST_WAIT2,
        ST_EVAL
    } state_t;

    state_t                state_reg, state_next;
    logic [SLOT_W-1:0]     wp_reg, wp_next;
    logic [SLOT_W-1:0]     rp_reg, rp_next;
    logic [EXP_W-1:0]      exp_reg, exp_next;
    logic [LIMIT_W-1:0]    limit_reg, limit_next;
    logic [SKIP_W-1:0]     skip_reg, skip_next;

    logic                  hold_valid_reg, hold_valid_next;
    logic [SLOT_W-1:0]     hold_idx_reg, hold_idx_next;
    logic [BYTE_W-1:0]     hold_sym_reg, hold_sym_next;
    logic [HANDLE_W-1:0]   hold_pay_reg, hold_pay_next;

    logic                  out_valid_reg, out_valid_next;
    logic                  out_kind_reg, out_kind_next;
    logic [CODE_W-1:0]     out_code_reg, out_code_next;
    logic [HANDLE_W-1:0]   out_handle_reg, out_handle_next;
    logic [SLOT_IDX_W-1:0] out_slot_reg, out_slot_next;
    logic [BYTE_W-1:0]     out_seq_reg, out_seq_next;
    logic                  out_last_reg, out_last_next;

    cell_ctrl_t            ctrl [RING_SLOTS];
    logic [RING_SLOTS-1:0] hit_chain;
    logic [RING_SLOTS-1:0] first_vec;
    logic [BYTE_W-1:0]     cell_sym [RING_SLOTS];
    logic [HANDLE_W-1:0]   cell_pay [RING_SLOTS];
    logic [BYTE_W-1:0]     exp_sym;
    pick_t                 pick;

    logic                  out_free;
    logic                  accept;
    logic                  wr_go;
    logic                  clr_go;
    logic [BACKLOG_W-1:0]  diff;
    logic [BACKLOG_W-1:0]  backlog;
    logic [EXP_W:0]        skip_sum;
    logic [EXP_W-1:0]      exp_skipped;
    logic [EXP_W-1:0]      exp_inc;

    assign exp_sym  = sym_of(exp_reg);
    assign out_free = !out_valid_reg || result.ready;
    assign accept   = pkt.valid && pkt.ready;

    assign pkt.ready = (state_reg == ST_IDLE) && out_free;
    assign cfg.ready = 1'b1;

    assign result.valid         = out_valid_reg;
    assign result.result_kind   = out_kind_reg;
    assign result.notice_code   = out_code_reg;
    assign result.packet_handle = out_handle_reg;
    assign result.slot_index    = out_slot_reg;
    assign result.released_seq  = out_seq_reg;
    assign result.is_last       = out_last_reg;

    genvar gi;
    generate
        for (gi = 0; gi < RING_SLOTS; gi++)
        begin : g_cell
            logic hit_in;
            if (gi % GROUP_SIZE == 0)
            begin : g_head
                assign hit_in = 1'b0;
            end
            else
            begin : g_body
                assign hit_in = hit_chain[gi-1];
            end

            assign ctrl[gi].wr_en  = wr_go && (wp_reg == SLOT_W'(gi));
            assign ctrl[gi].clr_en = clr_go && (pick.idx == SLOT_W'(gi));

            prb_cell u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .ctrl    (ctrl[gi]),
                .wr_sym  (pkt.seq_code),
                .wr_pay  (pkt.payload_handle),
                .exp_sym (exp_sym),
                .hit_in  (hit_in),
                .hit_out (hit_chain[gi]),
                .first   (first_vec[gi]),
                .sym     (cell_sym[gi]),
                .pay     (cell_pay[gi])
            );
        end
    endgenerate

    prb_pick u_pick (
        .clk   (clk),
        .rst_n (rst_n),
        .first (first_vec),
        .pick  (pick)
    );

    always_comb
    begin
        diff = BACKLOG_W'(wp_reg) + BACKLOG_W'(RING_SLOTS - 1) - BACKLOG_W'(rp_reg);
        if (diff >= BACKLOG_W'(RING_SLOTS))
        begin
            backlog = diff - BACKLOG_W'(RING_SLOTS);
        end
        else
        begin
            backlog = diff;
        end

        // skip count may exceed the alphabet, so the sum can wrap twice
        skip_sum = (EXP_W+1)'(exp_reg) + (EXP_W+1)'(skip_reg);
        if (skip_sum >= (EXP_W+1)'(2 * SYM_COUNT))
        begin
            exp_skipped = EXP_W'(skip_sum - (EXP_W+1)'(2 * SYM_COUNT));
        end
        else if (skip_sum >= (EXP_W+1)'(SYM_COUNT))
        begin
            exp_skipped = EXP_W'(skip_sum - (EXP_W+1)'(SYM_COUNT));
        end
        else
        begin
            exp_skipped = EXP_W'(skip_sum);
        end

        if (exp_reg == EXP_W'(SYM_COUNT - 1))
        begin
            exp_inc = '0;
        end
        else
        begin
            exp_inc = exp_reg + 1'b1;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        wp_next         = wp_reg;
        rp_next         = rp_reg;
        exp_next        = exp_reg;
        limit_next      = limit_reg;
        skip_next       = skip_reg;
        hold_valid_next = hold_valid_reg;
        hold_idx_next   = hold_idx_reg;
        hold_sym_next   = hold_sym_reg;
        hold_pay_next   = hold_pay_reg;
        out_valid_next  = out_valid_reg && !result.ready;
        out_kind_next   = out_kind_reg;
        out_code_next   = out_code_reg;
        out_handle_next = out_handle_reg;
        out_slot_next   = out_slot_reg;
        out_seq_next    = out_seq_reg;
        out_last_next   = out_last_reg;
        wr_go           = 1'b0;
        clr_go          = 1'b0;

        if (cfg.valid && cfg.ready)
        begin
            if (cfg.index == CFG_BACKLOG_LIMIT)
            begin
                limit_next = LIMIT_W'(cfg.data);
            end
            else if (cfg.index == CFG_SKIP_COUNT)
            begin
                skip_next = SKIP_W'(cfg.data);
            end
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (pkt.msg_kind <= KIND_STOP)
                    begin
                        out_valid_next  = 1'b1;
                        out_kind_next   = RESULT_NOTICE;
                        out_code_next   = CODE_W'(pkt.msg_kind);
                        out_handle_next = '0;
                        out_slot_next   = '0;
                        out_seq_next    = '0;
                        out_last_next   = 1'b1;
                    end
                    else if (pkt.msg_kind == KIND_DATA && pkt.first_byte == FRAME_START
                             && pkt.last_byte == FRAME_END)
                    begin
                        wr_go = 1'b1;
                        if (wp_reg == SLOT_W'(RING_SLOTS - 1))
                        begin
                            wp_next = '0;
                        end
                        else
                        begin
                            wp_next = wp_reg + 1'b1;
                        end
                        state_next = ST_WAIT1;
                    end
                end
            end
            ST_WAIT1:
            begin
                state_next = ST_WAIT2;
            end
            ST_WAIT2:
            begin
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                if (pick.hit)
                begin
                    if (!hold_valid_reg || out_free)
                    begin
                        if (hold_valid_reg)
                        begin
                            out_valid_next  = 1'b1;
                            out_kind_next   = RESULT_PACKET;
                            out_code_next   = '0;
                            out_handle_next = hold_pay_reg;
                            out_slot_next   = SLOT_IDX_W'(hold_idx_reg);
                            out_seq_next    = hold_sym_reg;
                            out_last_next   = 1'b0;
                        end
                        hold_valid_next = 1'b1;
                        hold_idx_next   = pick.idx;
                        hold_sym_next   = cell_sym[pick.idx];
                        hold_pay_next   = cell_pay[pick.idx];
                        clr_go          = 1'b1;
                        rp_next         = pick.idx;
                        exp_next        = exp_inc;
                        state_next      = ST_WAIT1;
                    end
                end
                else if (!hold_valid_reg || out_free)
                begin
                    if (hold_valid_reg)
                    begin
                        out_valid_next  = 1'b1;
                        out_kind_next   = RESULT_PACKET;
                        out_code_next   = '0;
                        out_handle_next = hold_pay_reg;
                        out_slot_next   = SLOT_IDX_W'(hold_idx_reg);
                        out_seq_next    = hold_sym_reg;
                        out_last_next   = 1'b1;
                    end
                    hold_valid_next = 1'b0;
                    if (6'(backlog) > 6'(limit_reg))
                    begin
                        exp_next = exp_skipped;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            wp_reg         <= '0;
            rp_reg         <= '0;
            exp_reg        <= '0;
            limit_reg      <= LIMIT_RESET;
            skip_reg       <= SKIP_RESET;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            wp_reg         <= wp_next;
            rp_reg         <= rp_next;
            exp_reg        <= exp_next;
            limit_reg      <= limit_next;
            skip_reg       <= skip_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_idx_reg   <= hold_idx_next;
        hold_sym_reg   <= hold_sym_next;
        hold_pay_reg   <= hold_pay_next;
        out_kind_reg   <= out_kind_next;
        out_code_reg   <= out_code_next;
        out_handle_reg <= out_handle_next;
        out_slot_reg   <= out_slot_next;
        out_seq_reg    <= out_seq_next;
        out_last_reg   <= out_last_next;
    end

endmodule

`default_nettype wire
